// ===== rtl/ordered_array_list_defines.svh =====
// assertion macros for the ordered array list checker
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define OLA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ordered_array_list check failed");

// next-cycle implication, disabled in reset
`define OLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ordered_array_list check failed");

`endif

// ===== rtl/ola_pkg.sv =====
// types and constants shared by the ordered array list
package ola_pkg;

  localparam int DEPTH = 16;
  localparam int DATA_W = 32;
  localparam int CAP_W = 5;
  localparam int POS_W = 4;
  localparam int OCC_W = 5;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WIDE_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    CMD_HEAD   = 2'd0,
    CMD_TAIL   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ACT_HOLD  = 3'd0,
    ACT_LOAD  = 3'd1,
    ACT_UP    = 3'd2,
    ACT_DOWN  = 3'd3,
    ACT_CLEAR = 3'd4
  } cell_act_t;

  typedef struct packed {
    cell_act_t act;
    data_t     data;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    S_COMPARE = 2'b01,
    S_UPDATE  = 2'b10
  } state_t;

endpackage

// ===== rtl/ola_cmd_if.sv =====
// command channel: command and value with valid/ready
interface ola_cmd_if;
  import ola_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  command;
  data_t       value;

  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

// ===== rtl/ola_res_if.sv =====
// result channel: status, position, occupancy and full flag with valid/ready
interface ola_res_if;
  import ola_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [POS_W-1:0] position;
  logic [OCC_W-1:0] occupancy;
  logic             full_res;

  modport source (output valid, status, position, occupancy, full_res, input ready);
  modport sink (input valid, status, position, occupancy, full_res, output ready);
endinterface

// ===== rtl/ola_cell.sv =====
// one list cell: holds an entry, compares it, shifts with its neighbors
module ola_cell (
  input  logic              clk,
  input  logic              rst,
  input  ola_pkg::cell_ctl_t ctl,
  input  ola_pkg::data_t    key,
  input  ola_pkg::data_t    below,
  input  ola_pkg::data_t    above,
  output ola_pkg::data_t    entry,
  output logic              hit
);
  import ola_pkg::*;

  data_t entry_next;

  assign hit = (entry == key);

  always_comb begin
    case (ctl.act)
      ACT_HOLD:  entry_next = entry;
      ACT_LOAD:  entry_next = ctl.data;
      ACT_UP:    entry_next = below;
      ACT_DOWN:  entry_next = above;
      ACT_CLEAR: entry_next = '0;
      default:   entry_next = entry;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

// ===== rtl/ordered_array_list.sv =====
// ordered array list top level: cell chain, command control and result register
// Each command passes through S_COMPARE, which compares the value against every
// cell of the chain at once and registers the match vector, then S_UPDATE, which
// shifts, loads or clears the cells and writes the result register. A new command
// is taken only in S_COMPARE; S_UPDATE waits while an earlier result is still
// held in the result register and not taken. The list starts empty with all
// entries zero and capacity 16 after reset; no clearing pass is needed.
module ordered_array_list (
  input  logic                    clk,
  input  logic                    rst,
  ola_cmd_if.sink                 cmd,
  ola_res_if.source               res,
  input  logic                    cfg_we,
  input  logic [ola_pkg::CAP_W-1:0] cfg_wdata
);
  import ola_pkg::*;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  cmd_t              cmd_q;
  data_t             val_q;
  logic [DEPTH-1:0]  match_q;

  data_t             entry [DEPTH];
  logic [DEPTH-1:0]  hit;
  logic [DEPTH-1:0]  held;
  cell_ctl_t         ctl [DEPTH];

  logic [DEPTH-1:0]  from_hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              found;
  logic [WIDE_W-1:0] eff_cap;
  logic              full_now;
  logic              full_next;
  logic              do_update;
  status_t           status_next;

  assign cmd.ready = (state == S_COMPARE);
  assign do_update = (state == S_UPDATE) && (!res.valid || res.ready);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      held[i] = (WIDE_W'(i) < WIDE_W'(count));
    end
  end

  always_comb begin
    eff_cap = WIDE_W'(capacity);
    if (eff_cap > WIDE_W'(DEPTH)) begin
      eff_cap = WIDE_W'(DEPTH);
    end
  end

  assign full_now = (WIDE_W'(count) >= eff_cap);
  assign full_next = (WIDE_W'(count_next) >= eff_cap);

  // first match and the cells at or above it
  always_comb begin
    found = |match_q;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    from_hit[0] = match_q[0];
    for (int i = 1; i < DEPTH; i++) begin
      from_hit[i] = from_hit[i-1] | match_q[i];
    end
  end

  always_comb begin
    count_next = count;
    status_next = ST_OK;
    case (cmd_q)
      CMD_HEAD, CMD_TAIL: begin
        if (full_now) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_SEARCH: begin
        if (!found) begin
          status_next = ST_MISS;
        end
      end
      CMD_DELETE: begin
        if (!found) begin
          status_next = ST_MISS;
        end else begin
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // per-cell action for the update cycle
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].data = val_q;
      ctl[i].act = ACT_HOLD;
      if (do_update) begin
        case (cmd_q)
          CMD_HEAD: begin
            if (!full_now) begin
              if (i == 0) begin
                ctl[i].act = ACT_LOAD;
              end else if (WIDE_W'(i) <= WIDE_W'(count)) begin
                ctl[i].act = ACT_UP;
              end
            end
          end
          CMD_TAIL: begin
            if (!full_now && (WIDE_W'(i) == WIDE_W'(count))) begin
              ctl[i].act = ACT_LOAD;
            end
          end
          CMD_DELETE: begin
            if (found) begin
              if (WIDE_W'(i) + WIDE_W'(1) == WIDE_W'(count)) begin
                ctl[i].act = ACT_CLEAR;
              end else if (from_hit[i] && held[i]) begin
                ctl[i].act = ACT_DOWN;
              end
            end
          end
          default: begin
            ctl[i].act = ACT_HOLD;
          end
        endcase
      end
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ola_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (ctl[g]),
      .key   (cmd.value),
      .below ((g == 0) ? data_t'(0) : entry[(g == 0) ? 0 : g - 1]),
      .above ((g == DEPTH - 1) ? data_t'(0) : entry[(g == DEPTH - 1) ? g : g + 1]),
      .entry (entry[g]),
      .hit   (hit[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_COMPARE;
      capacity <= CAP_RESET;
      count <= '0;
      res.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (do_update) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_COMPARE: begin
          if (cmd.valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (do_update) begin
            state <= S_COMPARE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_COMPARE;
        end
      endcase
    end
  end

  // command and match capture, result payload
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      cmd_q <= cmd_t'(cmd.command);
      val_q <= cmd.value;
      match_q <= hit & held;
    end
    if (do_update) begin
      res.status <= status_next;
      res.position <= ((cmd_q == CMD_SEARCH || cmd_q == CMD_DELETE) && found)
                      ? POS_W'(hit_idx) : '0;
      res.occupancy <= OCC_W'(count_next);
      res.full_res <= full_next;
    end
  end

endmodule

// ===== rtl/ola_checker.sv =====
// port-level checks for the ordered array list, bound to the top level
`include "ordered_array_list_defines.svh"

module ola_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     res_valid,
  input logic                     res_ready,
  input logic [1:0]               res_status,
  input logic [ola_pkg::POS_W-1:0] res_position,
  input logic [ola_pkg::OCC_W-1:0] res_occupancy,
  input logic                     res_full_res
);
  import ola_pkg::*;

  `OLA_ASSERT_NOW(a_occ_bound, res_valid, res_occupancy <= OCC_W'(DEPTH))
  `OLA_ASSERT_NOW(a_refused_full, res_valid && res_status == ST_FULL, res_full_res)
  `OLA_ASSERT_NOW(a_miss_pos, res_valid && res_status == ST_MISS, res_position == '0)
  `OLA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_occupancy))

endmodule

bind ordered_array_list ola_checker u_ola_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_status    (res.status),
  .res_position  (res.position),
  .res_occupancy (res.occupancy),
  .res_full_res  (res.full_res)
);

// ===== verif/ordered_array_list_tb.sv =====
`timescale 1ns / 100ps
// testbench for the ordered array list: directed table then random commands checked by a predictor
module ordered_array_list_tb;
  import ola_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
    logic             full;
  } list_result_t;

  typedef enum logic [1:0] {
    ROW_ITEM    = 2'd0,
    ROW_CHECKED = 2'd1,
    ROW_CAP     = 2'd2
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    cmd_t             command;
    data_t            value;
    logic [CAP_W-1:0] cap;
    status_t          status;
    logic [POS_W-1:0] position;
    logic [OCC_W-1:0] occupancy;
    logic             full;
  } row_t;

  localparam int N_ROWS = 29;
  localparam row_t DIRECTED [0:N_ROWS-1] = '{
    '{ROW_CHECKED, CMD_SEARCH, 32'sh0000_0000, 5'd0, ST_MISS, 4'd0, 5'd0, 1'b0},
    '{ROW_CHECKED, CMD_DELETE, 32'sh0000_0000, 5'd0, ST_MISS, 4'd0, 5'd0, 1'b0},
    '{ROW_CHECKED, CMD_HEAD, 32'sh7fff_ffff, 5'd0, ST_OK, 4'd0, 5'd1, 1'b0},
    '{ROW_CHECKED, CMD_TAIL, 32'sh8000_0000, 5'd0, ST_OK, 4'd0, 5'd2, 1'b0},
    '{ROW_ITEM, CMD_HEAD, 32'shffff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_TAIL, 32'sh0000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_TAIL, 32'sh7fff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_SEARCH, 32'sh7fff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_SEARCH, 32'sh0000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_DELETE, 32'sh8000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CHECKED, CMD_SEARCH, 32'sh8000_0000, 5'd0, ST_MISS, 4'd0, 5'd4, 1'b0},
    '{ROW_ITEM, CMD_DELETE, 32'shffff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_SEARCH, 32'sh0000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CAP, CMD_HEAD, 32'sh0000_0000, 5'd3, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CHECKED, CMD_TAIL, 32'sh0000_0005, 5'd0, ST_FULL, 4'd0, 5'd3, 1'b1},
    '{ROW_CAP, CMD_HEAD, 32'sh0000_0000, 5'd1, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CHECKED, CMD_HEAD, 32'sh0000_0006, 5'd0, ST_FULL, 4'd0, 5'd3, 1'b1},
    '{ROW_ITEM, CMD_DELETE, 32'sh7fff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_SEARCH, 32'sh7fff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CAP, CMD_HEAD, 32'sh0000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CHECKED, CMD_HEAD, 32'sh0000_0001, 5'd0, ST_FULL, 4'd0, 5'd2, 1'b1},
    '{ROW_CHECKED, CMD_TAIL, 32'sh0000_0001, 5'd0, ST_FULL, 4'd0, 5'd2, 1'b1},
    '{ROW_ITEM, CMD_DELETE, 32'sh0000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_SEARCH, 32'sh0000_0000, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_CAP, CMD_HEAD, 32'sh0000_0000, 5'd31, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_TAIL, 32'sh5555_5555, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_HEAD, 32'shaaaa_aaaa, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_DELETE, 32'sh7fff_ffff, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0},
    '{ROW_ITEM, CMD_SEARCH, 32'shaaaa_aaaa, 5'd0, ST_OK, 4'd0, 5'd0, 1'b0}
  };

  localparam int N_PHASES = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int SETTLE_CYCLES = 4;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  ola_cmd_if cmd_ch ();
  ola_res_if res_ch ();

  ordered_array_list u_dut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch),
    .res      (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // predicted list contents
  data_t            list_store [DEPTH];
  int               list_count;
  logic [CAP_W-1:0] cap_reg;

  list_result_t due_results [$];
  int           fails;
  bit           send_idle;
  bit           take_idle;

  function automatic list_result_t apply_command(cmd_t c, data_t v);
    list_result_t r;
    int           lim;
    int           hit;
    r.status = ST_OK;
    r.position = '0;
    lim = (cap_reg > DEPTH) ? DEPTH : int'(cap_reg);
    hit = -1;
    for (int i = 0; i < list_count; i++) begin
      if (hit < 0 && list_store[i] == v) hit = i;
    end
    case (c)
      CMD_HEAD, CMD_TAIL: begin
        if (list_count >= lim) begin
          r.status = ST_FULL;
        end else begin
          if (c == CMD_HEAD) begin
            for (int i = list_count; i > 0; i--) list_store[i] = list_store[i-1];
            list_store[0] = v;
          end else begin
            list_store[list_count] = v;
          end
          list_count++;
        end
      end
      default: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          r.position = POS_W'(hit);
          if (c == CMD_DELETE) begin
            for (int i = hit; i + 1 < list_count; i++) list_store[i] = list_store[i+1];
            list_count--;
            list_store[list_count] = '0;
          end
        end
      end
    endcase
    r.occupancy = OCC_W'(list_count);
    r.full = (list_count >= lim);
    return r;
  endfunction

  // called at a rising edge; returns at the edge of the transfer with valid still high
  task automatic send_cmd(cmd_t c, data_t v, bit typed, list_result_t typed_want);
    int           gap;
    list_result_t predicted;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= c;
    cmd_ch.value <= v;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    predicted = apply_command(c, v);
    due_results.push_back(typed ? typed_want : predicted);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cap_reg = c;
  endtask

  // result side stalls
  initial begin
    int stall;
    res_ch.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = take_idle ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_results.size() == 0) begin
        $error("result transfer with nothing expected");
        fails++;
      end else begin
        want = due_results.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, res_ch.status);
          fails++;
        end
        if (res_ch.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, res_ch.position);
          fails++;
        end
        if (res_ch.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, res_ch.occupancy);
          fails++;
        end
        if (res_ch.full_res !== want.full) begin
          $error("full_res: expected %0d, actual %0d", want.full, res_ch.full_res);
          fails++;
        end
      end
    end
  end

  initial begin
    #4_800_000;
    $display("ordered_array_list regression: fail");
    $finish;
  end

  initial begin
    list_result_t     typed_want;
    cmd_t             c;
    data_t            v;
    logic [CAP_W-1:0] phase_cap;
    int               ins_pct;
    int               pick;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_HEAD;
    cmd_ch.value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fails = 0;
    send_idle = 1'b1;
    take_idle = 1'b1;
    foreach (list_store[i]) list_store[i] = '0;
    list_count = 0;
    cap_reg = CAP_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].kind == ROW_CAP) begin
        write_capacity(DIRECTED[k].cap);
      end else begin
        typed_want.status = DIRECTED[k].status;
        typed_want.position = DIRECTED[k].position;
        typed_want.occupancy = DIRECTED[k].occupancy;
        typed_want.full = DIRECTED[k].full;
        send_cmd(DIRECTED[k].command, DIRECTED[k].value, DIRECTED[k].kind == ROW_CHECKED,
                 typed_want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: phase_cap = 5'd16;
        1: phase_cap = 5'd31;
        2: phase_cap = 5'd8;
        3: phase_cap = 5'd1;
        4: phase_cap = 5'd0;
        5: phase_cap = CAP_W'($urandom_range(1, 16));
        6: phase_cap = 5'd16;
        default: phase_cap = 5'd3;
      endcase
      write_capacity(phase_cap);
      send_idle = (ph % 3 != 1);
      take_idle = (ph % 3 != 2);
      ins_pct = (ph % 2 == 0) ? 60 : 45;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        if ($urandom_range(0, 99) < ins_pct) begin
          c = cmd_t'($urandom_range(0, 1));
          pick = $urandom_range(0, 99);
          if (pick < 40) v = data_t'($urandom_range(0, 7)) - 4;
          else if (pick < 50) v = pick[0] ? 32'sh8000_0000 : 32'sh7fff_ffff;
          else v = data_t'($urandom);
        end else begin
          c = cmd_t'($urandom_range(2, 3));
          pick = $urandom_range(0, 99);
          if (pick < 60 && list_count > 0)
            v = list_store[$urandom_range(0, list_count - 1)];
          else if (pick < 85) v = data_t'($urandom_range(0, 7)) - 4;
          else v = data_t'($urandom);
        end
        send_cmd(c, v, 1'b0, '0);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("ordered_array_list regression: pass");
    end else begin
      $display("ordered_array_list regression: fail");
    end
    $finish;
  end

endmodule

// ===== ordered_array_list.f =====
+incdir+rtl
rtl/ola_pkg.sv
rtl/ola_cmd_if.sv
rtl/ola_res_if.sv
rtl/ola_cell.sv
rtl/ordered_array_list.sv
rtl/ola_checker.sv
verif/ordered_array_list_tb.sv
